@@ rtl/assert_macros.svh @@
// Assertion macros shared by the gain mix block.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define GMAD_ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("gmad same-cycle check failed");

// Next-cycle implication, checked out of reset
`define GMAD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("gmad next-cycle check failed");

`endif

@@ rtl/gmad_pkg.sv @@
// Shared constants, codes and queue entry type of the gain mix block.
// Depends on nothing; used by every other file but assert_macros.svh.
package gmad_pkg;

	// Defaults of the top level parameters
	localparam int PERIOD_MAX_DEF = 256;
	localparam int SUM_BITS_DEF   = 24;

	// Field widths fixed by the item format
	localparam int KIND_W   = 2;
	localparam int OFFSET_W = 24;
	localparam int INDEX_W  = 9;
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int RPOS_W   = 8;
	localparam int OUT_W    = 24;
	localparam int PLACE_W  = 2;
	localparam int USAGE_W  = 2;
	localparam int PERIOD_W = 9;

	// Period register
	localparam int PERIOD_MIN = 32;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd256;

	// Widest buffer address (covers buffers of up to 4096 frames)
	localparam int ADDR_MAX_W = 12;

	// Offset remainder unit: bits retired per cycle
	localparam int DIV_BITS   = 4;
	localparam int DIV_CYCLES = OFFSET_W / DIV_BITS;
	localparam int STEP_W     = $clog2(DIV_CYCLES);

	// Queue between front and back
	localparam int Q_DEPTH = 2;

	// Product and rounding
	localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
	localparam int ROUND_SHIFT = 14;
	localparam int RND_W       = PROD_W + 1 - ROUND_SHIFT;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_MIX   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NOP   = 2'd3;

	// Operations handed from front to back
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_MIX_FIRST  = 3'd0;
	localparam logic [OP_W-1:0] OP_MIX_SECOND = 3'd1;
	localparam logic [OP_W-1:0] OP_DROP       = 3'd2;
	localparam logic [OP_W-1:0] OP_READ       = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;
	localparam logic [OP_W-1:0] OP_NOP        = 3'd5;

	// Placement codes
	localparam logic [PLACE_W-1:0] PL_FIRST  = 2'd0;
	localparam logic [PLACE_W-1:0] PL_SECOND = 2'd1;
	localparam logic [PLACE_W-1:0] PL_DROP   = 2'd2;
	localparam logic [PLACE_W-1:0] PL_NONE   = 2'd3;

	// Usage mark codes
	localparam logic [USAGE_W-1:0] US_NONE  = 2'd0;
	localparam logic [USAGE_W-1:0] US_FIRST = 2'd1;
	localparam logic [USAGE_W-1:0] US_BOTH  = 2'd2;

	// Classified item waiting for the back part
	typedef struct packed {
		logic [OP_W-1:0]            op;
		logic [ADDR_MAX_W-1:0]      addr;
		logic signed [SAMPLE_W-1:0] sample_left;
		logic signed [SAMPLE_W-1:0] sample_right;
		logic [GAIN_W-1:0]          gain_left;
		logic [GAIN_W-1:0]          gain_right;
	} fe_entry_t;

endpackage

@@ rtl/gmad_if.sv @@
// Handshake channels of the gain mix block: input items and results.
// Depends on gmad_pkg for field widths.
interface gmad_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [gmad_pkg::KIND_W-1:0]          kind;
	logic [gmad_pkg::OFFSET_W-1:0]        block_offset;
	logic [gmad_pkg::INDEX_W-1:0]         frame_index;
	logic signed [gmad_pkg::SAMPLE_W-1:0] sample_left;
	logic signed [gmad_pkg::SAMPLE_W-1:0] sample_right;
	logic [gmad_pkg::GAIN_W-1:0]          gain_left;
	logic [gmad_pkg::GAIN_W-1:0]          gain_right;
	logic [gmad_pkg::RPOS_W-1:0]          read_position;

	modport source (
		output valid, kind, block_offset, frame_index, sample_left, sample_right,
			gain_left, gain_right, read_position,
		input ready
	);
	modport sink (
		input valid, kind, block_offset, frame_index, sample_left, sample_right,
			gain_left, gain_right, read_position,
		output ready
	);
endinterface

interface gmad_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [gmad_pkg::OUT_W-1:0] sum_left;
	logic signed [gmad_pkg::OUT_W-1:0] sum_right;
	logic [gmad_pkg::PLACE_W-1:0]      placement;
	logic [gmad_pkg::USAGE_W-1:0]      usage_mark;
	logic                              clipped;

	modport source (
		output valid, sum_left, sum_right, placement, usage_mark, clipped,
		input ready
	);
	modport sink (
		input valid, sum_left, sum_right, placement, usage_mark, clipped,
		output ready
	);
endinterface

@@ rtl/gmad_queue.sv @@
// Short queue of classified items between the front and back parts.
// Depends on gmad_pkg for the entry type and depth.
module gmad_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gmad_pkg::fe_entry_t entry,
	output logic                full,
	input  logic                pop,
	output logic                valid,
	output gmad_pkg::fe_entry_t head
);
	localparam int PTR_W = $clog2(gmad_pkg::Q_DEPTH);
	localparam int CNT_W = $clog2(gmad_pkg::Q_DEPTH + 1);

	gmad_pkg::fe_entry_t ent_q [gmad_pkg::Q_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    cnt_q;

	assign full  = (cnt_q == CNT_W'(gmad_pkg::Q_DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = ent_q[rd_ptr_q];

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= entry;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(gmad_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(gmad_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

@@ rtl/gmad_front.sv @@
// Front part: takes items, holds the period register, reduces the block
// offset modulo the period and classifies each item. Depends on gmad_pkg, gmad_if.
module gmad_front #(
	parameter int PERIOD_MAX = gmad_pkg::PERIOD_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [gmad_pkg::PERIOD_W-1:0]   cfg_wr_data,
	gmad_in_if.sink                         items,
	input  logic                            clearing,
	input  logic                            q_full,
	output logic                            q_push,
	output gmad_pkg::fe_entry_t             q_entry
);
	localparam int PW = $clog2(PERIOD_MAX + 1);
	localparam int XW = ((PW > gmad_pkg::INDEX_W) ? PW : gmad_pkg::INDEX_W) + 1;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]                          fs_q;
	logic [gmad_pkg::PERIOD_W-1:0]       period_q;
	logic [gmad_pkg::KIND_W-1:0]         kind_q;
	logic [gmad_pkg::OFFSET_W-1:0]       off_q;
	logic [gmad_pkg::INDEX_W-1:0]        fidx_q;
	logic signed [gmad_pkg::SAMPLE_W-1:0] sl_q;
	logic signed [gmad_pkg::SAMPLE_W-1:0] sr_q;
	logic [gmad_pkg::GAIN_W-1:0]         gl_q;
	logic [gmad_pkg::GAIN_W-1:0]         gr_q;
	logic [gmad_pkg::RPOS_W-1:0]         rpos_q;
	logic [XW-1:0]                       rem_q;
	logic [gmad_pkg::STEP_W-1:0]         step_q;

	logic [XW-1:0] per_c;
	logic [XW-1:0] rem_step;
	logic [XW-1:0] pos;
	logic [XW-1:0] pos_second;
	logic          accept;

	// Period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= gmad_pkg::PERIOD_RESET;
		end else if (cfg_wr_en) begin
			period_q <= cfg_wr_data;
		end
	end

	// Clamp the period to the supported range
	always_comb begin
		if (period_q < gmad_pkg::PERIOD_W'(gmad_pkg::PERIOD_MIN)) begin
			per_c = XW'(gmad_pkg::PERIOD_MIN);
		end else if (XW'(period_q) > XW'(PERIOD_MAX)) begin
			per_c = XW'(PERIOD_MAX);
		end else begin
			per_c = XW'(period_q);
		end
	end

	// Retire DIV_BITS offset bits into the remainder per cycle
	always_comb begin
		rem_step = rem_q;
		for (int i = 0; i < gmad_pkg::DIV_BITS; i++) begin
			rem_step = {rem_step[XW-2:0], off_q[gmad_pkg::OFFSET_W-1-i]};
			if (rem_step >= per_c) begin
				rem_step = rem_step - per_c;
			end
		end
	end

	assign accept       = items.valid && items.ready;
	assign items.ready  = (fs_q == F_IDLE) && !clearing;
	assign pos          = rem_q + XW'(fidx_q);
	assign pos_second   = pos - per_c;
	assign q_push       = (fs_q == F_PUSH) && !q_full;

	// Classify the held item into a back-part operation
	always_comb begin
		q_entry.sample_left  = sl_q;
		q_entry.sample_right = sr_q;
		q_entry.gain_left    = gl_q;
		q_entry.gain_right   = gr_q;
		q_entry.op           = gmad_pkg::OP_NOP;
		q_entry.addr         = '0;
		case (kind_q)
			gmad_pkg::KIND_MIX: begin
				if (pos < per_c) begin
					q_entry.op   = gmad_pkg::OP_MIX_FIRST;
					q_entry.addr = gmad_pkg::ADDR_MAX_W'(pos);
				end else if (pos_second < per_c) begin
					q_entry.op   = gmad_pkg::OP_MIX_SECOND;
					q_entry.addr = gmad_pkg::ADDR_MAX_W'(pos_second);
				end else begin
					q_entry.op = gmad_pkg::OP_DROP;
				end
			end
			gmad_pkg::KIND_READ: begin
				if (32'(rpos_q) < PERIOD_MAX) begin
					q_entry.op   = gmad_pkg::OP_READ;
					q_entry.addr = gmad_pkg::ADDR_MAX_W'(rpos_q);
				end
			end
			gmad_pkg::KIND_CLEAR: begin
				q_entry.op = gmad_pkg::OP_CLEAR;
			end
			default: begin
				q_entry.op = gmad_pkg::OP_NOP;
			end
		endcase
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= items.kind;
			fidx_q <= items.frame_index;
			sl_q   <= items.sample_left;
			sr_q   <= items.sample_right;
			gl_q   <= items.gain_left;
			gr_q   <= items.gain_right;
			rpos_q <= items.read_position;
		end
	end

	// Sequence accept, remainder steps and push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q   <= F_IDLE;
			off_q  <= '0;
			rem_q  <= '0;
			step_q <= '0;
		end else begin
			case (fs_q)
				F_IDLE: begin
					if (accept) begin
						off_q  <= items.block_offset;
						rem_q  <= '0;
						step_q <= '0;
						fs_q   <= (items.kind == gmad_pkg::KIND_MIX) ? F_DIV : F_PUSH;
					end
				end
				F_DIV: begin
					rem_q  <= rem_step;
					off_q  <= off_q << gmad_pkg::DIV_BITS;
					step_q <= step_q + 1'b1;
					if (step_q == gmad_pkg::STEP_W'(gmad_pkg::DIV_CYCLES - 1)) begin
						fs_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (q_push) begin
						fs_q <= F_IDLE;
					end
				end
				default: begin
					fs_q <= F_IDLE;
				end
			endcase
		end
	end
endmodule

@@ rtl/gmad_back.sv @@
// Back part: owns both period buffers and the usage mark, performs the
// read-modify-write, reads and clearing sweeps. Depends on gmad_pkg, gmad_if.
module gmad_back #(
	parameter int PERIOD_MAX = gmad_pkg::PERIOD_MAX_DEF,
	parameter int SUM_BITS   = gmad_pkg::SUM_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  gmad_pkg::fe_entry_t q_head,
	output logic                q_pop,
	output logic                clearing,
	gmad_out_if.source          results
);
	localparam int AW = $clog2(PERIOD_MAX);
	localparam int MW = 2 * SUM_BITS;
	localparam int RW = gmad_pkg::RND_W;
	localparam int SW = ((SUM_BITS > RW) ? SUM_BITS : RW) + 1;
	localparam int PW = gmad_pkg::PROD_W;
	localparam logic signed [SW-1:0] SUM_HI = SW'((64'sd1 <<< (SUM_BITS - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SUM_LO = ~SUM_HI;
	localparam logic signed [PW:0]   ROUND_BIAS = (PW + 1)'(1 << (gmad_pkg::ROUND_SHIFT - 1));

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_WR   = 2'd1;
	localparam logic [1:0] B_CLR  = 2'd2;

	logic [MW-1:0] first_mem  [PERIOD_MAX];
	logic [MW-1:0] second_mem [PERIOD_MAX];

	logic [1:0]                    state_q;
	logic [AW-1:0]                 clr_cnt_q;
	logic [gmad_pkg::USAGE_W-1:0]  usage_q;
	logic [gmad_pkg::OP_W-1:0]     op_s1;
	logic [AW-1:0]                 addr_s1;
	logic signed [PW-1:0]          prod_l_s1;
	logic signed [PW-1:0]          prod_r_s1;
	logic [MW-1:0]                 rd_first_q;
	logic [MW-1:0]                 rd_second_q;

	logic                              out_valid_q;
	logic signed [gmad_pkg::OUT_W-1:0] sum_left_q;
	logic signed [gmad_pkg::OUT_W-1:0] sum_right_q;
	logic [gmad_pkg::PLACE_W-1:0]      place_q;
	logic [gmad_pkg::USAGE_W-1:0]      usage_out_q;
	logic                              clip_q;

	logic                              out_free;
	logic [AW-1:0]                     rd_addr;
	logic [MW-1:0]                     base;
	logic signed [PW:0]                biased_l;
	logic signed [PW:0]                biased_r;
	logic signed [RW-1:0]              rnd_l;
	logic signed [RW-1:0]              rnd_r;
	logic [SUM_BITS:0]                 sat_l;
	logic [SUM_BITS:0]                 sat_r;
	logic signed [SUM_BITS-1:0]        val_l;
	logic signed [SUM_BITS-1:0]        val_r;
	logic signed [SUM_BITS-1:0]        rd_l;
	logic signed [SUM_BITS-1:0]        rd_r;

	logic                              load_out;
	logic signed [gmad_pkg::OUT_W-1:0] nxt_sum_l;
	logic signed [gmad_pkg::OUT_W-1:0] nxt_sum_r;
	logic [gmad_pkg::PLACE_W-1:0]      nxt_place;
	logic [gmad_pkg::USAGE_W-1:0]      nxt_usage;
	logic                              nxt_clip;
	logic                              first_we;
	logic                              second_we;
	logic [AW-1:0]                     wr_addr;
	logic [MW-1:0]                     wr_data;

	// Add and saturate; the top bit flags saturation
	function automatic logic [SUM_BITS:0] sat_add(
		input logic signed [SUM_BITS-1:0] acc,
		input logic signed [RW-1:0]       add
	);
		logic signed [SW-1:0] s;
		logic [SUM_BITS:0]    r;
		s = SW'(acc) + SW'(add);
		if (s > SUM_HI) begin
			r = {1'b1, SUM_HI[SUM_BITS-1:0]};
		end else if (s < SUM_LO) begin
			r = {1'b1, SUM_LO[SUM_BITS-1:0]};
		end else begin
			r = {1'b0, s[SUM_BITS-1:0]};
		end
		return r;
	endfunction

	assign out_free = !out_valid_q || results.ready;
	assign q_pop    = (state_q == B_IDLE) && q_valid && out_free;
	assign clearing = (state_q == B_CLR);
	assign rd_addr  = q_head.addr[AW-1:0];

	// Round products to Q.15 with floor after adding half
	assign biased_l = (PW + 1)'(prod_l_s1) + ROUND_BIAS;
	assign biased_r = (PW + 1)'(prod_r_s1) + ROUND_BIAS;
	assign rnd_l    = biased_l[PW:gmad_pkg::ROUND_SHIFT];
	assign rnd_r    = biased_r[PW:gmad_pkg::ROUND_SHIFT];

	// Accumulate into the frame of the target buffer
	assign base  = (op_s1 == gmad_pkg::OP_MIX_FIRST) ? rd_first_q : rd_second_q;
	assign sat_l = sat_add(base[SUM_BITS-1:0], rnd_l);
	assign sat_r = sat_add(base[MW-1:SUM_BITS], rnd_r);
	assign val_l = sat_l[SUM_BITS-1:0];
	assign val_r = sat_r[SUM_BITS-1:0];
	assign rd_l  = rd_first_q[SUM_BITS-1:0];
	assign rd_r  = rd_first_q[MW-1:SUM_BITS];

	// Decide result, usage mark and buffer writes
	always_comb begin
		load_out  = 1'b0;
		nxt_sum_l = '0;
		nxt_sum_r = '0;
		nxt_place = gmad_pkg::PL_NONE;
		nxt_usage = usage_q;
		nxt_clip  = 1'b0;
		first_we  = 1'b0;
		second_we = 1'b0;
		wr_addr   = clr_cnt_q;
		wr_data   = '0;
		case (state_q)
			B_IDLE: begin
				if (q_pop) begin
					case (q_head.op)
						gmad_pkg::OP_DROP: begin
							load_out  = 1'b1;
							nxt_place = gmad_pkg::PL_DROP;
							nxt_usage = gmad_pkg::US_BOTH;
						end
						gmad_pkg::OP_CLEAR: begin
							load_out  = 1'b1;
							nxt_usage = gmad_pkg::US_NONE;
						end
						gmad_pkg::OP_NOP: begin
							load_out = 1'b1;
						end
						default: begin
							load_out = 1'b0;
						end
					endcase
				end
			end
			B_WR: begin
				load_out = 1'b1;
				case (op_s1)
					gmad_pkg::OP_MIX_FIRST: begin
						nxt_sum_l = gmad_pkg::OUT_W'(val_l);
						nxt_sum_r = gmad_pkg::OUT_W'(val_r);
						nxt_place = gmad_pkg::PL_FIRST;
						nxt_usage = (usage_q == gmad_pkg::US_NONE) ? gmad_pkg::US_FIRST : usage_q;
						nxt_clip  = sat_l[SUM_BITS] || sat_r[SUM_BITS];
						first_we  = 1'b1;
						wr_addr   = addr_s1;
						wr_data   = {val_r, val_l};
					end
					gmad_pkg::OP_MIX_SECOND: begin
						nxt_sum_l = gmad_pkg::OUT_W'(val_l);
						nxt_sum_r = gmad_pkg::OUT_W'(val_r);
						nxt_place = gmad_pkg::PL_SECOND;
						nxt_usage = gmad_pkg::US_BOTH;
						nxt_clip  = sat_l[SUM_BITS] || sat_r[SUM_BITS];
						second_we = 1'b1;
						wr_addr   = addr_s1;
						wr_data   = {val_r, val_l};
					end
					default: begin
						nxt_sum_l = gmad_pkg::OUT_W'(rd_l);
						nxt_sum_r = gmad_pkg::OUT_W'(rd_r);
					end
				endcase
			end
			B_CLR: begin
				first_we  = 1'b1;
				second_we = 1'b1;
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	// First buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (first_we) begin
			first_mem[wr_addr] <= wr_data;
		end
		if (q_pop) begin
			rd_first_q <= first_mem[rd_addr];
		end
	end

	// Second buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (second_we) begin
			second_mem[wr_addr] <= wr_data;
		end
		if (q_pop) begin
			rd_second_q <= second_mem[rd_addr];
		end
	end

	// Capture the popped item and its products
	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1     <= q_head.op;
			addr_s1   <= q_head.addr[AW-1:0];
			prod_l_s1 <= PW'(q_head.sample_left) * PW'($signed({1'b0, q_head.gain_left}));
			prod_r_s1 <= PW'(q_head.sample_right) * PW'($signed({1'b0, q_head.gain_right}));
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			sum_left_q  <= nxt_sum_l;
			sum_right_q <= nxt_sum_r;
			place_q     <= nxt_place;
			usage_out_q <= nxt_usage;
			clip_q      <= nxt_clip;
		end
	end

	// Sequencer, usage mark, clear sweep and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLR;
			clr_cnt_q   <= '0;
			usage_q     <= gmad_pkg::US_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				usage_q     <= nxt_usage;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						if (q_head.op == gmad_pkg::OP_MIX_FIRST ||
							q_head.op == gmad_pkg::OP_MIX_SECOND ||
							q_head.op == gmad_pkg::OP_READ) begin
							state_q <= B_WR;
						end else if (q_head.op == gmad_pkg::OP_CLEAR) begin
							state_q <= B_CLR;
						end
					end
				end
				B_WR: begin
					state_q <= B_IDLE;
				end
				B_CLR: begin
					if (clr_cnt_q == AW'(PERIOD_MAX - 1)) begin
						clr_cnt_q <= '0;
						state_q   <= B_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign results.valid      = out_valid_q;
	assign results.sum_left   = sum_left_q;
	assign results.sum_right  = sum_right_q;
	assign results.placement  = place_q;
	assign results.usage_mark = usage_out_q;
	assign results.clipped    = clip_q;
endmodule

@@ rtl/gain_mix_accumulate_double_buffer_top.sv @@
// Channel    Role     Handshake       Payload
// cfg_wr_*   config   write enable    period_frames (9 bit)
// items      input    valid/ready     kind, offset, index, samples, gains, read position
// results    output   valid/ready     sums, placement, usage mark, clip flag
//
// Front: a mix item is accepted, its offset remainder is formed at four bits a
// cycle, then it is pushed; other items go from accept straight to push. Back: mix
// and read read the buffers, then mix accumulates and writes back; drop, no-op and
// clear report at the pop, then clear sweeps both buffers to zero, as after reset,
// while items wait. A stalled result register does not stop the front; the queue fills.
//
// Top level of the stereo gain mix-accumulate block with two period buffers.
// Depends on gmad_pkg, gmad_if, gmad_queue, gmad_front, gmad_back, assert_macros.svh.
`include "assert_macros.svh"

module gain_mix_accumulate_double_buffer_top #(
	parameter int PERIOD_MAX = gmad_pkg::PERIOD_MAX_DEF,
	parameter int SUM_BITS   = gmad_pkg::SUM_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [gmad_pkg::PERIOD_W-1:0] cfg_wr_data,
	gmad_in_if.sink                       items,
	gmad_out_if.source                    results
);
	logic                q_push;
	logic                q_pop;
	logic                q_full;
	logic                q_valid;
	logic                clearing;
	gmad_pkg::fe_entry_t q_entry;
	gmad_pkg::fe_entry_t q_head;

	// Accept and classify
	gmad_front #(
		.PERIOD_MAX (PERIOD_MAX)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.items       (items),
		.clearing    (clearing),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_entry)
	);

	// Decouple front and back
	gmad_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.entry  (q_entry),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.head   (q_head)
	);

	// Execute on the buffers
	gmad_back #(
		.PERIOD_MAX (PERIOD_MAX),
		.SUM_BITS   (SUM_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.clearing (clearing),
		.results  (results)
	);

	// No item enters while the buffers are being swept
	`GMAD_ASSERT_SAME(a_no_accept_clear, clk, arst_n, clearing, !items.ready)
	// The front never pushes into a full queue
	`GMAD_ASSERT_SAME(a_push_room, clk, arst_n, q_push, !q_full)
	// A popped clear starts the sweep on the next cycle
	`GMAD_ASSERT_NEXT(a_clear_sweep, clk, arst_n, q_pop && q_head.op == gmad_pkg::OP_CLEAR, clearing)
	// A dropped frame reports zero sums and no clip
	`GMAD_ASSERT_SAME(a_drop_zero, clk, arst_n, results.valid && results.placement == gmad_pkg::PL_DROP, results.sum_left == '0 && results.sum_right == '0 && !results.clipped)
endmodule

@@ tb/gmad_mix_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard of the gain mix block: watches the item and result channels, keeps its
// own copy of both period buffers and the usage mark, and checks each result in order.
// Depends on gmad_pkg and the channel interfaces of gmad_if.
module gmad_mix_checker
	import gmad_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [PERIOD_W-1:0] cfg_wr_data,
	gmad_in_if                  items,
	gmad_out_if                 results,
	output int                  errors,
	output int                  outstanding
);

	localparam int DEPTH = PERIOD_MAX_DEF;
	localparam longint SUM_HI = (longint'(1) << (OUT_W - 1)) - 1;
	localparam longint SUM_LO = -SUM_HI - 1;

	typedef struct packed {
		logic signed [OUT_W-1:0] sum_left;
		logic signed [OUT_W-1:0] sum_right;
		logic [PLACE_W-1:0]      placement;
		logic [USAGE_W-1:0]      usage_mark;
		logic                    clipped;
	} frame_result_t;

	// Model state: two period buffers of left/right sums, usage mark, period register
	logic signed [OUT_W-1:0] first_buf [DEPTH][2];
	logic signed [OUT_W-1:0] second_buf [DEPTH][2];
	logic [USAGE_W-1:0]      usage;
	logic [PERIOD_W-1:0]     period_reg;
	frame_result_t           expected_frames [$];

	// Scale one sample by its Q2.14 gain, round to Q.15 and add with saturation
	function automatic logic signed [OUT_W-1:0] mac_saturate(
		input logic signed [OUT_W-1:0]    acc,
		input logic signed [SAMPLE_W-1:0] smp,
		input logic [GAIN_W-1:0]          gn,
		inout logic                       clip
	);
		longint prod;
		longint total;
		prod = longint'(smp) * longint'(gn);
		total = longint'(acc) + ((prod + 64'sd8192) >>> ROUND_SHIFT);
		if (total > SUM_HI) begin
			total = SUM_HI;
			clip = 1'b1;
		end
		if (total < SUM_LO) begin
			total = SUM_LO;
			clip = 1'b1;
		end
		return OUT_W'(total);
	endfunction

	// Apply one item to the model buffers and return the result it must produce
	function automatic frame_result_t predict_frame_result(
		input logic [KIND_W-1:0]          kind,
		input logic [OFFSET_W-1:0]        offset,
		input logic [INDEX_W-1:0]         index,
		input logic signed [SAMPLE_W-1:0] sl,
		input logic signed [SAMPLE_W-1:0] sr,
		input logic [GAIN_W-1:0]          gl,
		input logic [GAIN_W-1:0]          gr,
		input logic [RPOS_W-1:0]          rpos
	);
		frame_result_t r;
		int span;
		int pos;
		logic clip;
		r = '{sum_left: '0, sum_right: '0, placement: PL_NONE, usage_mark: US_NONE,
			clipped: 1'b0};
		clip = 1'b0;
		case (kind)
			KIND_MIX: begin
				span = int'(period_reg);
				if (span < PERIOD_MIN) span = PERIOD_MIN;
				if (span > DEPTH) span = DEPTH;
				pos = int'(offset) % span + int'(index);
				if (pos < span) begin
					first_buf[pos][0] = mac_saturate(first_buf[pos][0], sl, gl, clip);
					first_buf[pos][1] = mac_saturate(first_buf[pos][1], sr, gr, clip);
					r.sum_left = first_buf[pos][0];
					r.sum_right = first_buf[pos][1];
					r.placement = PL_FIRST;
					if (usage == US_NONE) usage = US_FIRST;
				end else if (pos < 2 * span) begin
					pos = pos - span;
					second_buf[pos][0] = mac_saturate(second_buf[pos][0], sl, gl, clip);
					second_buf[pos][1] = mac_saturate(second_buf[pos][1], sr, gr, clip);
					r.sum_left = second_buf[pos][0];
					r.sum_right = second_buf[pos][1];
					r.placement = PL_SECOND;
					usage = US_BOTH;
				end else begin
					// past both buffers: drop, only the mark moves
					r.placement = PL_DROP;
					usage = US_BOTH;
				end
			end
			KIND_READ: begin
				// stale frames beyond the current period are still returned
				if (int'(rpos) < DEPTH) begin
					r.sum_left = first_buf[rpos][0];
					r.sum_right = first_buf[rpos][1];
				end
			end
			KIND_CLEAR: begin
				for (int i = 0; i < DEPTH; i++) begin
					first_buf[i] = '{'0, '0};
					second_buf[i] = '{'0, '0};
				end
				usage = US_NONE;
			end
			default: begin
			end
		endcase
		r.clipped = clip;
		r.usage_mark = usage;
		return r;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Track config writes, check results, then queue the prediction of a new item
	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		frame_result_t pred;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				first_buf[i] = '{'0, '0};
				second_buf[i] = '{'0, '0};
			end
			usage = US_NONE;
			period_reg = PERIOD_RESET;
			expected_frames.delete();
			errors = 0;
		end else begin
			if (cfg_wr_en) period_reg = cfg_wr_data;
			if (results.valid && results.ready) begin
				if (expected_frames.size() == 0) begin
					$display("%0t: result with no item outstanding, expected none, got sums %0d %0d placement %0d",
						$time, results.sum_left, results.sum_right, results.placement);
					errors++;
				end else begin
					want = expected_frames.pop_front();
					check_field("sum_left", longint'(want.sum_left), longint'(results.sum_left));
					check_field("sum_right", longint'(want.sum_right),
						longint'(results.sum_right));
					check_field("placement", want.placement, results.placement);
					check_field("usage_mark", want.usage_mark, results.usage_mark);
					check_field("clipped", want.clipped, results.clipped);
				end
			end
			if (items.valid && items.ready) begin
				pred = predict_frame_result(items.kind, items.block_offset,
					items.frame_index, items.sample_left, items.sample_right, items.gain_left,
					items.gain_right, items.read_position);
				expected_frames = {expected_frames, pred};
			end
		end
		outstanding = expected_frames.size();
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Top of the gain mix block testbench: clock, reset, item and result traffic,
// period changes and the verdict. Depends on gmad_pkg, gmad_if, the block top
// and gmad_mix_checker, which does all prediction and comparison.
module tb;
	import gmad_pkg::*;

	localparam int RANDOM_ITEMS  = 1450;
	localparam int PHASES        = 10;
	localparam int SETTLE_CYCLES = 300;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd16384;
	localparam logic [PERIOD_W-1:0] PHASE_PERIODS [PHASES] = '{
		9'd32, 9'd511, 9'd0, 9'd256, 9'd100, 9'd257, 9'd31, 9'd200, 9'd64, 9'd255
	};

	typedef struct {
		logic [KIND_W-1:0]          kind;
		logic [OFFSET_W-1:0]        block_offset;
		logic [INDEX_W-1:0]         frame_index;
		logic signed [SAMPLE_W-1:0] sample_left;
		logic signed [SAMPLE_W-1:0] sample_right;
		logic [GAIN_W-1:0]          gain_left;
		logic [GAIN_W-1:0]          gain_right;
		logic [RPOS_W-1:0]          read_position;
	} mix_item_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [PERIOD_W-1:0] cfg_wr_data;
	int                  errors;
	int                  outstanding;
	int                  items_sent;
	bit                  calm;

	gmad_in_if  items ();
	gmad_out_if results ();

	gain_mix_accumulate_double_buffer_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.items       (items),
		.results     (results)
	);

	gmad_mix_checker mix_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.items       (items),
		.results     (results),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Fill every field at random, then set the kind
	function automatic mix_item_t make_item(input logic [KIND_W-1:0] kind);
		mix_item_t it;
		it.kind = kind;
		it.block_offset = OFFSET_W'($urandom);
		it.frame_index = INDEX_W'($urandom);
		it.sample_left = SAMPLE_W'($urandom);
		it.sample_right = SAMPLE_W'($urandom);
		it.gain_left = GAIN_W'($urandom);
		it.gain_right = GAIN_W'($urandom);
		it.read_position = RPOS_W'($urandom);
		return it;
	endfunction

	function automatic mix_item_t mix_frame(
		input logic [OFFSET_W-1:0]        off,
		input logic [INDEX_W-1:0]         idx,
		input logic signed [SAMPLE_W-1:0] sl,
		input logic signed [SAMPLE_W-1:0] sr,
		input logic [GAIN_W-1:0]          gl,
		input logic [GAIN_W-1:0]          gr
	);
		mix_item_t it;
		it = make_item(KIND_MIX);
		it.block_offset = off;
		it.frame_index = idx;
		it.sample_left = sl;
		it.sample_right = sr;
		it.gain_left = gl;
		it.gain_right = gr;
		return it;
	endfunction

	function automatic mix_item_t read_frame(input logic [RPOS_W-1:0] rpos);
		mix_item_t it;
		it = make_item(KIND_READ);
		it.read_position = rpos;
		return it;
	endfunction

	// Hold off a random number of cycles, then offer the item until accepted
	task automatic push_item(input mix_item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items.valid <= 1'b1;
		items.kind <= it.kind;
		items.block_offset <= it.block_offset;
		items.frame_index <= it.frame_index;
		items.sample_left <= it.sample_left;
		items.sample_right <= it.sample_right;
		items.gain_left <= it.gain_left;
		items.gain_right <= it.gain_right;
		items.read_position <= it.read_position;
		do @(posedge clk); while (!items.ready);
		items_sent++;
	endtask

	// Stop offering items and wait for every outstanding result
	task automatic drain();
		items.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic write_period(input logic [PERIOD_W-1:0] value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Result side: stall a random number of cycles before each result
	initial begin
		int gap;
		results.ready <= 1'b0;
		@(posedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				results.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			results.ready <= 1'b1;
			do @(posedge clk); while (!(results.valid && results.ready));
		end
	end

	initial begin
		int span;
		int pick;
		int run_len;
		int first_idx;
		int goal;
		logic [OFFSET_W-1:0]        off;
		logic [INDEX_W-1:0]         idx;
		logic signed [SAMPLE_W-1:0] sl;
		logic signed [SAMPLE_W-1:0] sr;
		logic [GAIN_W-1:0]          gl;
		logic [GAIN_W-1:0]          gr;

		calm = 1'b0;
		items_sent = 0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		items.valid <= 1'b0;
		items.kind <= KIND_NOP;
		items.block_offset <= '0;
		items.frame_index <= '0;
		items.sample_left <= '0;
		items.sample_right <= '0;
		items.gain_left <= '0;
		items.gain_right <= '0;
		items.read_position <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: oversized period clamps to the full buffer
		write_period(9'd511);
		push_item(read_frame(8'd0));
		push_item(make_item(KIND_NOP));
		push_item(mix_frame(24'd0, 9'd0, 16'sh7FFF, 16'sh8000, 16'hFFFF, 16'hFFFF));
		push_item(mix_frame(24'd0, 9'd0, 16'sh8000, 16'sh7FFF, 16'hFFFF, 16'h0000));
		// largest offset and index: past both buffers
		push_item(mix_frame(24'hFFFFFF, 9'd511, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF));
		// first frame of the second buffer; rounding of half steps
		push_item(mix_frame(24'd255, 9'd1, 16'sd1, -16'sd1, 16'd8192, 16'd8192));
		push_item(mix_frame(24'd0, 9'd511, -16'sd1, -16'sd1, 16'd8193, UNITY_GAIN));
		push_item(mix_frame(24'd0, 9'd255, 16'sh7FFF, 16'sh7FFF, UNITY_GAIN, UNITY_GAIN));
		push_item(read_frame(8'd255));
		push_item(read_frame(8'd0));
		push_item(make_item(KIND_CLEAR));
		push_item(read_frame(8'd0));
		push_item(make_item(KIND_NOP));
		push_item(mix_frame(24'd256, 9'd0, 16'sd12345, -16'sd12345, UNITY_GAIN, UNITY_GAIN));

		// Directed: undersized period clamps to the minimum, buffers kept
		write_period(9'd0);
		push_item(mix_frame(24'hFFFFFF, 9'd0, 16'sd1000, -16'sd1000, UNITY_GAIN, UNITY_GAIN));
		push_item(mix_frame(24'hFFFFFF, 9'd1, 16'sd2000, -16'sd2000, UNITY_GAIN, UNITY_GAIN));
		push_item(mix_frame(24'd32, 9'd31, 16'sd3000, 16'sd3000, 16'd20000, 16'd40000));
		push_item(mix_frame(24'hFFFFFF, 9'd33, 16'sd4000, 16'sd4000, UNITY_GAIN, UNITY_GAIN));
		push_item(read_frame(8'd200));
		push_item(read_frame(8'd31));

		// Random phases, one period setting each
		for (int ph = 0; ph < PHASES; ph++) begin
			write_period(PHASE_PERIODS[ph]);
			calm = (ph % 3 == 2);
			span = int'(PHASE_PERIODS[ph]);
			if (span < PERIOD_MIN) span = PERIOD_MIN;
			if (span > PERIOD_MAX_DEF) span = PERIOD_MAX_DEF;
			goal = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 57) begin
					// source block: consecutive frames from one start offset
					off = ($urandom_range(0, 3) == 0) ? OFFSET_W'($urandom_range(0, 2 * span))
						: OFFSET_W'($urandom);
					run_len = $urandom_range(1, 48);
					first_idx = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 512 - run_len);
					for (int n = 0; n < run_len; n++) begin
						gl = ($urandom_range(0, 3) == 0) ? UNITY_GAIN : GAIN_W'($urandom);
						gr = ($urandom_range(0, 3) == 0) ? UNITY_GAIN : GAIN_W'($urandom);
						push_item(mix_frame(off, INDEX_W'(first_idx + n), SAMPLE_W'($urandom),
							SAMPLE_W'($urandom), gl, gr));
					end
				end else if (pick < 65) begin
					// hammer one frame with loud samples to drive it into saturation
					off = OFFSET_W'($urandom);
					idx = INDEX_W'($urandom_range(0, 2 * span - 1));
					sl = SAMPLE_W'($urandom_range(28000, 32767));
					sr = SAMPLE_W'($urandom_range(28000, 32767));
					if ($urandom_range(0, 1) == 1) sl = ~sl;
					if ($urandom_range(0, 1) == 1) sr = ~sr;
					repeat ($urandom_range(20, 90)) begin
						push_item(mix_frame(off, idx, sl, sr, GAIN_W'($urandom_range(49152, 65535)),
							GAIN_W'($urandom_range(49152, 65535))));
					end
				end else if (pick < 82) begin
					repeat ($urandom_range(1, 8)) begin
						push_item(read_frame(($urandom_range(0, 1) == 0)
							? RPOS_W'($urandom_range(0, span - 1)) : RPOS_W'($urandom)));
					end
				end else if (pick < 87) begin
					push_item(make_item(KIND_CLEAR));
				end else begin
					// noise: any kind, any field
					repeat ($urandom_range(1, 6)) push_item(make_item(KIND_W'($urandom_range(0, 3))));
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/gmad_pkg.sv
rtl/gmad_if.sv
rtl/gmad_queue.sv
rtl/gmad_front.sv
rtl/gmad_back.sv
rtl/gain_mix_accumulate_double_buffer_top.sv
tb/gmad_mix_checker.sv
tb/tb.sv
